// ===== sv/fpl2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpl2_pkg: shared constants and types for the fixed-point log2 unit
// Widths of the operand and result, normalizer step plan and FSM state types.
// ----------------------------------------------------------------------------
package fpl2_pkg;

  localparam int IN_W           = 32;  // operand width
  localparam int OUT_W          = 30;  // result width, two's complement
  localparam int EXP_W          = 7;   // signed integer part, -64..63
  localparam int LZ_W           = 5;   // leading zero count, 0..31
  localparam int NORM_STEPS     = 5;   // binary search steps over 32 bits
  localparam int NORM_STEP_W    = 3;
  localparam int NORM_FIRST     = 16;  // first search step shifts by 16
  localparam int FRACTION_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_NORM,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } back_state_t;

endpackage : fpl2_pkg
`default_nettype wire

// ===== sv/fpl2_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpl2_front: request intake and normalizer
// Finds the leading one by a five-step binary search and pushes the
// integer part and the mantissa in [1,2) to the queue.
// ----------------------------------------------------------------------------
module fpl2_front #(
  parameter int FRACTION_BITS = fpl2_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [fpl2_pkg::IN_W-1:0]       in_value_in,
  output logic                                 push_valid,
  input  wire logic                            push_stall,
  output logic signed [fpl2_pkg::EXP_W-1:0]    push_expo,
  output logic [FRACTION_BITS:0]               push_mant
);
  import fpl2_pkg::*;

  localparam int MANT_W = FRACTION_BITS + 1;

  front_state_t           state_r, state_nxt;
  logic [IN_W-1:0]        x_r, x_nxt;
  logic [LZ_W-1:0]        lz_r, lz_nxt;
  logic [NORM_STEP_W-1:0] step_r, step_nxt;
  logic [LZ_W:0]          amt;
  logic [IN_W-1:0]        top_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    lz_r   <= lz_nxt;
    step_r <= step_nxt;
  end

  // shift amount of this search step: 16, 8, 4, 2, 1
  assign amt      = (LZ_W + 1)'(NORM_FIRST >> step_r);
  assign top_mask = ~({IN_W{1'b1}} >> amt);

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    lz_nxt     = lz_r;
    step_nxt   = step_r;
    in_stall   = 1'b1;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          x_nxt     = in_value_in;
          lz_nxt    = '0;
          step_nxt  = '0;
          state_nxt = F_NORM;
        end
      end
      F_NORM: begin
        if ((x_r & top_mask) == '0) begin
          x_nxt  = x_r << amt;
          lz_nxt = lz_r + LZ_W'(amt);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == NORM_STEP_W'(NORM_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (!push_stall) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // x_r is left-justified; a zero operand ends with lz of 31 and mantissa 0,
  // which yields the minimum result without a special path
  assign push_expo = EXP_W'(IN_W - 1) - EXP_W'(lz_r) - EXP_W'(FRACTION_BITS);
  assign push_mant = x_r[IN_W-1 -: MANT_W];

endmodule : fpl2_front
`default_nettype wire

// ===== sv/fpl2_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpl2_fifo: two-entry queue between normalizer and squaring engine
// Register based, first word fall-through.
// ----------------------------------------------------------------------------
module fpl2_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_stall,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_stall,
  output logic [WIDTH-1:0]      pop_data
);
  import fpl2_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : fpl2_fifo
`default_nettype wire

// ===== sv/fpl2_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpl2_back: repeated-squaring engine
// One squaring per cycle on a shared multiplier, one fraction bit per round,
// result held in an output register until taken.
// ----------------------------------------------------------------------------
module fpl2_back #(
  parameter int FRACTION_BITS = fpl2_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            pop_valid,
  output logic                                 pop_stall,
  input  wire logic signed [fpl2_pkg::EXP_W-1:0] pop_expo,
  input  wire logic [FRACTION_BITS:0]          pop_mant,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [fpl2_pkg::OUT_W-1:0]           out_log2_out
);
  import fpl2_pkg::*;

  localparam int MANT_W = FRACTION_BITS + 1;
  localparam int CNT_W  = $clog2(FRACTION_BITS);
  localparam int ACC_W  = (FRACTION_BITS + EXP_W > OUT_W) ? FRACTION_BITS + EXP_W : OUT_W;

  back_state_t              state_r, state_nxt;
  logic [MANT_W-1:0]        z_r, z_nxt;
  logic [FRACTION_BITS-1:0] frac_r, frac_nxt;
  logic signed [EXP_W-1:0]  expo_r, expo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_data_r, out_data_nxt;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          sq_trunc;
  logic signed [ACC_W-1:0]  acc;

  // z < 2.0, so the square stays below 4.0
  assign sq       = z_r * z_r;
  assign sq_trunc = sq[2*MANT_W-1:FRACTION_BITS];

  // integer part placed above the collected fraction bits, high bits wrap away
  assign acc = (ACC_W'(expo_r) <<< FRACTION_BITS) | ACC_W'(frac_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    z_r        <= z_nxt;
    frac_r     <= frac_nxt;
    expo_r     <= expo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    z_nxt         = z_r;
    frac_nxt      = frac_r;
    expo_nxt      = expo_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop_stall     = 1'b1;
    case (state_r)
      B_IDLE: begin
        pop_stall = 1'b0;
        if (pop_valid) begin
          z_nxt     = pop_mant;
          expo_nxt  = pop_expo;
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (sq_trunc[MANT_W]) begin
          z_nxt    = sq_trunc[MANT_W:1];
          frac_nxt = {frac_r[FRACTION_BITS-2:0], 1'b1};
        end else begin
          z_nxt    = sq_trunc[MANT_W-1:0];
          frac_nxt = {frac_r[FRACTION_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRACTION_BITS - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc[OUT_W-1:0];
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_log2_out = out_data_r;

endmodule : fpl2_back
`default_nettype wire

// ===== sv/fixed_point_log2_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_log2_unit: base-2 logarithm of an unsigned fixed-point value
// Normalizer front end, two-entry queue, repeated-squaring back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one request: in_value_in, an
//   unsigned 32-bit value with FRACTION_BITS fraction bits.
//   Output channel out_valid / out_stall returns out_log2_out, the truncated
//   log2 in two's complement with FRACTION_BITS fraction bits (low 30 bits).
//   A zero operand returns -FRACTION_BITS.
// Operation:
//   The front end works on one request at a time (accept, five leading-one
//   search steps, queue push). The back end runs FRACTION_BITS squarings on
//   one multiplier, one per cycle, plus load and write-back, takes no new
//   request until its write-back is done, and sets the sustained rate.
// Reset and stalls:
//   Synchronous active-low reset empties the queue and drops both FSMs to
//   idle; out_valid is low afterwards. While out_stall is high the result
//   holds in its output register; the engine and the queue keep taking
//   requests until they fill, then in_stall stays high.
// ----------------------------------------------------------------------------
module fixed_point_log2_unit #(
  parameter int FRACTION_BITS = fpl2_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [fpl2_pkg::IN_W-1:0]  in_value_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [fpl2_pkg::OUT_W-1:0]      out_log2_out
);
  import fpl2_pkg::*;

  localparam int MANT_W = FRACTION_BITS + 1;
  localparam int Q_W    = EXP_W + MANT_W;

  // normalizer to queue
  logic                    push_valid, push_stall;
  logic signed [EXP_W-1:0] push_expo;
  logic [MANT_W-1:0]       push_mant;

  // queue to squaring engine
  logic                    pop_valid, pop_stall;
  logic [Q_W-1:0]          pop_data;
  logic signed [EXP_W-1:0] pop_expo;
  logic [MANT_W-1:0]       pop_mant;

  fpl2_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value_in(in_value_in),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_expo  (push_expo),
    .push_mant  (push_mant)
  );

  fpl2_fifo #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_data ({push_expo, push_mant}),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data)
  );

  assign pop_expo = pop_data[Q_W-1:MANT_W];
  assign pop_mant = pop_data[MANT_W-1:0];

  fpl2_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_stall   (pop_stall),
    .pop_expo    (pop_expo),
    .pop_mant    (pop_mant),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_log2_out(out_log2_out)
  );

endmodule : fixed_point_log2_unit
`default_nettype wire

// ===== dv/fixed_point_log2_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fixed_point_log2_unit
// Drives unsigned fixed-point operands with bursty request timing and a
// randomly stalling receiver, predicts each truncated log2 result, and
// compares every returned result in order against the predicted value.
// ----------------------------------------------------------------------------
module testbench;

  import fpl2_pkg::*;

  localparam int FB         = FRACTION_BITS_DEF;  // fraction bits under test
  localparam int MAX_REPORT = 10;                 // mismatches printed in full
  localparam int RANDOM_REQ = 460;                // size of the random phase
  localparam int HOLD_LONG  = 300;                // receiver hold-off, cycles

  // Receiver stall behaviors; a new one is drawn at random at the end of each epoch
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;
  localparam int STALL_EPOCH = 50;

  // One accepted request: the operand and the log2 value it must produce
  typedef struct {
    logic [IN_W-1:0]  operand;
    logic [OUT_W-1:0] log2_val;
  } log2_request_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [IN_W-1:0]   in_value_in  = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [OUT_W-1:0]  out_log2_out;

  log2_request_t     log2_expected[$];  // predicted results, oldest first
  int                fail_count   = 0;
  int                rx_hold_left = 0;  // pending receiver hold-off cycles

  fixed_point_log2_unit #(
    .FRACTION_BITS(FB)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value_in (in_value_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_log2_out(out_log2_out)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Log2 predictor. Normalize into [1,2) with at most FB left shifts (each
  // costs one) and then right shifts (each adds one); then FB squaring
  // rounds, each truncated back to FB fraction bits. A square at or above
  // two is halved and contributes the current fraction bit. The running sum
  // wraps modulo 2^64 and only its low OUT_W bits leave the block.
  // --------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] log2_fixed(input logic [IN_W-1:0] operand);
    logic [63:0] one_q;
    logic [63:0] two_q;
    logic [63:0] acc;
    logic [63:0] frac_bit;
    logic [63:0] mant;
    int          shifts;
    one_q    = 64'd1 << FB;
    two_q    = 64'd2 << FB;
    acc      = '0;
    frac_bit = 64'd1 << (FB - 1);
    mant     = {32'd0, operand};
    shifts   = 0;
    // zero never reaches one: it runs out of shifts and ends at -FB
    while (shifts < FB && mant < one_q) begin
      mant   = mant << 1;
      acc    = acc - one_q;
      shifts = shifts + 1;
    end
    while (mant >= two_q) begin
      mant = mant >> 1;
      acc  = acc + one_q;
    end
    // mant < 2^(FB+1) here, so the square fits comfortably in 64 bits
    for (int r = 0; r < FB; r++) begin
      mant = (mant * mant) >> FB;
      if (mant >= two_q) begin
        mant = mant >> 1;
        acc  = acc + frac_bit;
      end
      frac_bit = frac_bit >> 1;
    end
    return acc[OUT_W-1:0];
  endfunction

  // Operand mix: wide random values plus the corners where normalization
  // and squaring change behavior (zero, tiny values, powers of two, near one)
  function automatic logic [IN_W-1:0] pick_operand();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = 32'd1 << $urandom_range(0, IN_W - 1);
      2:       v = (32'd1 << $urandom_range(0, IN_W - 1)) + $urandom_range(0, 3) - 2;
      3, 4:    v = $urandom >> $urandom_range(0, IN_W - 1);
      5:       v = (32'd1 << FB) + $urandom_range(0, 64) - 32;
      6:       v = $urandom_range(1, 255);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a request is taken at
  // the rising edge where in_stall is low. Valid stays high on return so a
  // following request goes out back to back; pause_sender drops it.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [IN_W-1:0] operand);
    log2_request_t req;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_value_in <= operand;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req.operand  = operand;
    req.log2_val = log2_fixed(operand);
    log2_expected.push_back(req);
  endtask

  // Holds valid low for the given number of cycles (at least one)
  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (log2_expected.size() != 0) @(posedge clk);
  endtask

  // Bursts of random length; gaps mostly short, sometimes longer than one
  // back-end pass so idle time lands on every phase of the squaring loop
  task automatic send_bursts(input int count);
    int sent;
    int burst_len;
    sent = 0;
    while (sent < count) begin
      burst_len = $urandom_range(1, 16);
      for (int k = 0; k < burst_len && sent < count; k++) begin
        send_request(pick_operand());
        sent++;
      end
      if ($urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 40));
      else
        pause_sender($urandom_range(1, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Stall pattern changes mode every epoch; a pending hold-off
  // overrides it and keeps out_stall high for its full count.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode  = STALL_NONE;
  int          epoch_count = 0;

  always @(negedge clk) begin
    if (epoch_count == STALL_EPOCH - 1) begin
      epoch_count <= 0;
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
    end else begin
      epoch_count <= epoch_count + 1;
    end
    if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_TOGGLE: out_stall <= epoch_count[1];
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted result must match the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    log2_request_t req;
    if (rst_n && out_valid && !out_stall) begin
      if (log2_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORT)
          $display("unexpected result: log2 %0d", $signed(out_log2_out));
      end else begin
        req = log2_expected.pop_front();
        if (out_log2_out !== req.log2_val) begin
          fail_count++;
          if (fail_count <= MAX_REPORT)
            $display("log2(0x%08h): expected %0d, got %0d", req.operand,
                     $signed(req.log2_val), $signed(out_log2_out));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corners: zero, smallest nonzero values, one and its neighbors, powers of
  // two on both sides of one, the largest operands
  task automatic test_directed();
    logic [IN_W-1:0] corner[$];
    corner = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
               32'h0100_0000, 32'h00FF_FFFF, 32'h0100_0001, 32'h0080_0000,
               32'h0200_0000, 32'h01FF_FFFF, 32'h0300_0000, 32'h0180_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
               32'h5555_5555, 32'h0000_8000, 32'h0001_0000, 32'h0000_0100};
    foreach (corner[i]) send_request(corner[i]);
    pause_sender(1);
  endtask

  // Receiver holds off long enough for the front end and queue to fill and
  // in_stall to rise while requests keep coming back to back
  task automatic test_backpressure();
    @(posedge clk);
    rx_hold_left = HOLD_LONG;
    repeat (16) send_request(pick_operand());
    pause_sender(1);
  endtask

  task automatic test_random_bursts();
    send_bursts(RANDOM_REQ);
  endtask

  // Sender goes quiet until every outstanding result is back, then resumes
  task automatic test_drain_pause();
    repeat (8) send_request(pick_operand());
    pause_sender(1);
    wait_drained();
    send_bursts(12);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_bursts();
    test_drain_pause();

    // let any stray result surface before judging
    wait_drained();
    repeat (FB + 20) @(posedge clk);
    if (fail_count == 0 && log2_expected.size() == 0)
      $display("fixed_point_log2_unit: match");
    else
      $display("fixed_point_log2_unit: mismatch");
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #1_000_000;
    $display("fixed_point_log2_unit: mismatch");
    $finish;
  end

endmodule
